>>> src/rpmc_pkg.sv
package rpmc_pkg;

    localparam int MAX_COLS   = 32;
    localparam int MAX_ROWS   = 32;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int CELL_W     = COL_W + ROW_W;
    localparam int CELL_TOTAL = MAX_COLS * MAX_ROWS;
    localparam int MARK_DEPTH = 1 << CELL_W;
    localparam int IDX_W      = $clog2(CELL_TOTAL);
    localparam int CNT_W      = $clog2(CELL_TOTAL + 1);
    localparam int DIMC_W     = $clog2(MAX_COLS + 1);
    localparam int DIMR_W     = $clog2(MAX_ROWS + 1);

    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_POS_W  = 5;

    localparam int LFSR_W     = 16;
    localparam int BIT_CNT_W  = $clog2(LFSR_W);
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;

    localparam logic [1:0] MARK_UNVISITED = 2'd0;
    localparam logic [1:0] MARK_FRONTIER  = 2'd1;
    localparam logic [1:0] MARK_INMAZE    = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_CLEAR    = 11'b000_0000_0010,
        S_DIV      = 11'b000_0000_0100,
        S_FRD_IDX  = 11'b000_0000_1000,
        S_FRD_LAST = 11'b000_0001_0000,
        S_FSWAP    = 11'b000_0010_0000,
        S_MARK     = 11'b000_0100_0000,
        S_NREAD    = 11'b000_1000_0000,
        S_PICK     = 11'b001_0000_0000,
        S_GROW     = 11'b010_0000_0000,
        S_OUT      = 11'b100_0000_0000
    } t_state;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        return (s >> 1) ^ (s[0] ? LFSR_TAPS : '0);
    endfunction

endpackage

>>> src/rpmc_ram.sv
module rpmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/random_prim_maze_carver.sv
// Randomised Prim maze carver.
// Input channel (i_valid / o_stall) takes one transaction per item: i_restart high
// starts a new maze seeded from i_seed, i_restart low carves one step. Every item
// yields exactly one result transaction on the output channel (o_valid / i_stall):
// the cell just joined, whether a passage was carved, its direction and whether
// the frontier is now empty.
// The configuration channel (i_cfg_valid / o_cfg_ready, always ready) sets the grid
// columns (index 0) and rows (index 1); new sizes apply from the next restart.
// One item is in flight at a time; o_stall is high from acceptance until its
// result is taken, and the next item can be taken the cycle after that.
// A restart sweeps the whole cell-mark memory of a 32 x 32 store, one entry a cycle,
// before it offers its result. A step runs two modulo draws on one shared
// restoring divider plus frontier and mark memory traffic. A step on an empty
// frontier offers its result in the cycle after acceptance.
// Results wait in the output registers while i_stall is high; nothing is lost.
// Synchronous reset clears the frontier, seeds the LFSR with one and sets both
// grid sizes to 32; marks are only read after a restart has cleared them.
module random_prim_maze_carver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_restart,
    input  logic [15:0]                   i_seed,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_carved,
    output logic [4:0]                    o_cell_col,
    output logic [4:0]                    o_cell_row,
    output logic [1:0]                    o_direction,
    output logic                          o_done_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rpmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpmc_pkg::CFG_W-1:0]     i_cfg_data
);

    rpmc_pkg::t_state n_state, r_state;

    logic [rpmc_pkg::CFG_W-1:0]     r_grid_cols, r_grid_rows;
    logic [rpmc_pkg::DIMC_W-1:0]    r_live_cols;
    logic [rpmc_pkg::DIMR_W-1:0]    r_live_rows;
    logic [rpmc_pkg::CNT_W-1:0]     r_count;
    logic [rpmc_pkg::LFSR_W-1:0]    r_lfsr;
    logic                           r_restart;
    logic [rpmc_pkg::CELL_W-1:0]    r_clr_addr;

    logic [rpmc_pkg::LFSR_W-1:0]    r_dividend;
    logic [rpmc_pkg::CNT_W-1:0]     r_divisor, r_rem;
    logic [rpmc_pkg::BIT_CNT_W-1:0] r_bit;
    logic                           r_second;
    logic [rpmc_pkg::CNT_W:0]       div_trial;
    logic [rpmc_pkg::CNT_W-1:0]     n_rem;

    logic [rpmc_pkg::IDX_W-1:0]     r_idx;
    logic [1:0]                     r_k;
    logic [rpmc_pkg::ROW_W-1:0]     r_row;
    logic [rpmc_pkg::COL_W-1:0]     r_col;
    logic [2:0]                     r_d;
    logic [3:0]                     r_inmaze, r_unv;
    logic                           r_carved;
    logic [1:0]                     r_dir;

    logic [3:0]                     nb_ok;
    logic [1:0]                     cap_d;
    logic [1:0]                     pick_dir;
    logic [2:0]                     pick_seen;

    logic                           m_we;
    logic [rpmc_pkg::CELL_W-1:0]    m_waddr, m_raddr;
    logic [1:0]                     m_wdata, m_rdata;
    logic                           f_we;
    logic [rpmc_pkg::IDX_W-1:0]     f_waddr, f_raddr;
    logic [rpmc_pkg::CELL_W-1:0]    f_wdata, f_rdata;

    logic in_acc, out_acc, grow_ok;

    function automatic logic [rpmc_pkg::DIMC_W-1:0] clamp_cols(
        input logic [rpmc_pkg::CFG_W-1:0] v);
        if (v == '0) return rpmc_pkg::DIMC_W'(1);
        if (int'(v) > rpmc_pkg::MAX_COLS) return rpmc_pkg::DIMC_W'(rpmc_pkg::MAX_COLS);
        return rpmc_pkg::DIMC_W'(v);
    endfunction

    function automatic logic [rpmc_pkg::DIMR_W-1:0] clamp_rows(
        input logic [rpmc_pkg::CFG_W-1:0] v);
        if (v == '0) return rpmc_pkg::DIMR_W'(1);
        if (int'(v) > rpmc_pkg::MAX_ROWS) return rpmc_pkg::DIMR_W'(rpmc_pkg::MAX_ROWS);
        return rpmc_pkg::DIMR_W'(v);
    endfunction

    function automatic logic [rpmc_pkg::CELL_W-1:0] nb_cell(
        input logic [1:0]                 d,
        input logic [rpmc_pkg::ROW_W-1:0] row,
        input logic [rpmc_pkg::COL_W-1:0] col);
        logic [rpmc_pkg::CELL_W-1:0] c;
        unique case (d)
            rpmc_pkg::DIR_UP:    c = {rpmc_pkg::ROW_W'(row - 1'b1), col};
            rpmc_pkg::DIR_DOWN:  c = {rpmc_pkg::ROW_W'(row + 1'b1), col};
            rpmc_pkg::DIR_LEFT:  c = {row, rpmc_pkg::COL_W'(col - 1'b1)};
            rpmc_pkg::DIR_RIGHT: c = {row, rpmc_pkg::COL_W'(col + 1'b1)};
            default:             c = {row, col};
        endcase
        return c;
    endfunction

    assign in_acc      = i_valid && !o_stall;
    assign out_acc     = o_valid && !i_stall;
    assign o_stall     = (r_state != rpmc_pkg::S_IDLE);
    assign o_valid     = (r_state == rpmc_pkg::S_OUT);
    assign o_cfg_ready = 1'b1;
    assign o_carved    = r_carved;
    assign o_cell_col  = rpmc_pkg::OUT_POS_W'(r_col);
    assign o_cell_row  = rpmc_pkg::OUT_POS_W'(r_row);
    assign o_direction = r_dir;
    assign o_done_res  = (r_count == '0);

    assign nb_ok[0] = (r_row != '0);
    assign nb_ok[1] = (rpmc_pkg::DIMR_W'(r_row) + 1'b1 < r_live_rows);
    assign nb_ok[2] = (r_col != '0);
    assign nb_ok[3] = (rpmc_pkg::DIMC_W'(r_col) + 1'b1 < r_live_cols);

    assign cap_d   = 2'(r_d - 3'd1);
    assign grow_ok = r_unv[r_d[1:0]] && (r_count < rpmc_pkg::CNT_W'(rpmc_pkg::CELL_TOTAL));

    assign div_trial = {r_rem, r_dividend[rpmc_pkg::LFSR_W-1]};
    assign n_rem = (div_trial >= {1'b0, r_divisor})
                 ? rpmc_pkg::CNT_W'(div_trial - {1'b0, r_divisor})
                 : rpmc_pkg::CNT_W'(div_trial);

    always_comb begin
        pick_dir  = rpmc_pkg::DIR_UP;
        pick_seen = '0;
        for (int d = 0; d < 4; d++) begin
            if (r_inmaze[d]) begin
                if (pick_seen == {1'b0, r_k}) begin
                    pick_dir = 2'(d);
                end
                pick_seen = pick_seen + 3'd1;
            end
        end
    end

    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_clr_addr;
        m_wdata = rpmc_pkg::MARK_UNVISITED;
        m_raddr = nb_cell(r_d[1:0], r_row, r_col);
        f_we    = 1'b0;
        f_waddr = r_idx;
        f_wdata = f_rdata;
        f_raddr = r_idx;
        unique case (r_state)
            rpmc_pkg::S_CLEAR: begin
                m_we = 1'b1;
            end
            rpmc_pkg::S_FRD_LAST: begin
                f_raddr = rpmc_pkg::IDX_W'(r_count - 1'b1);
            end
            rpmc_pkg::S_FSWAP: begin
                f_we = 1'b1;
            end
            rpmc_pkg::S_MARK: begin
                m_we    = 1'b1;
                m_waddr = {r_row, r_col};
                m_wdata = rpmc_pkg::MARK_INMAZE;
            end
            rpmc_pkg::S_GROW: begin
                m_we    = grow_ok;
                m_waddr = nb_cell(r_d[1:0], r_row, r_col);
                m_wdata = rpmc_pkg::MARK_FRONTIER;
                f_we    = grow_ok;
                f_waddr = rpmc_pkg::IDX_W'(r_count);
                f_wdata = nb_cell(r_d[1:0], r_row, r_col);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpmc_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_restart) begin
                        n_state = rpmc_pkg::S_CLEAR;
                    end else if (r_count == '0) begin
                        n_state = rpmc_pkg::S_OUT;
                    end else begin
                        n_state = rpmc_pkg::S_DIV;
                    end
                end
            end
            rpmc_pkg::S_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = rpmc_pkg::S_MARK;
                end
            end
            rpmc_pkg::S_DIV: begin
                if (r_bit == '1) begin
                    n_state = r_second ? rpmc_pkg::S_PICK : rpmc_pkg::S_FRD_IDX;
                end
            end
            rpmc_pkg::S_FRD_IDX:  n_state = rpmc_pkg::S_FRD_LAST;
            rpmc_pkg::S_FRD_LAST: n_state = rpmc_pkg::S_FSWAP;
            rpmc_pkg::S_FSWAP:    n_state = rpmc_pkg::S_MARK;
            rpmc_pkg::S_MARK:     n_state = rpmc_pkg::S_NREAD;
            rpmc_pkg::S_NREAD: begin
                if (r_d == 3'd5) begin
                    if (!r_restart && (r_inmaze != '0)) begin
                        n_state = rpmc_pkg::S_DIV;
                    end else begin
                        n_state = rpmc_pkg::S_GROW;
                    end
                end
            end
            rpmc_pkg::S_PICK: n_state = rpmc_pkg::S_GROW;
            rpmc_pkg::S_GROW: begin
                if (r_d[1:0] == 2'd3) begin
                    n_state = rpmc_pkg::S_OUT;
                end
            end
            rpmc_pkg::S_OUT: begin
                if (out_acc) begin
                    n_state = rpmc_pkg::S_IDLE;
                end
            end
            default: n_state = rpmc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpmc_pkg::S_IDLE;
            r_grid_cols <= rpmc_pkg::CFG_W'(32);
            r_grid_rows <= rpmc_pkg::CFG_W'(32);
            r_live_cols <= clamp_cols(rpmc_pkg::CFG_W'(32));
            r_live_rows <= clamp_rows(rpmc_pkg::CFG_W'(32));
            r_count     <= '0;
            r_lfsr      <= rpmc_pkg::LFSR_W'(1);
            r_restart   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == rpmc_pkg::CFG_GRID_COLS) begin
                    r_grid_cols <= i_cfg_data;
                end else if (i_cfg_index == rpmc_pkg::CFG_GRID_ROWS) begin
                    r_grid_rows <= i_cfg_data;
                end
            end

            unique case (r_state)
                rpmc_pkg::S_IDLE: begin
                    r_carved <= 1'b0;
                    r_dir    <= rpmc_pkg::DIR_UP;
                    r_row    <= '0;
                    r_col    <= '0;
                    if (in_acc) begin
                        r_restart <= i_restart;
                        if (i_restart) begin
                            r_lfsr      <= (i_seed == '0) ? rpmc_pkg::LFSR_W'(1) : i_seed;
                            r_live_cols <= clamp_cols(r_grid_cols);
                            r_live_rows <= clamp_rows(r_grid_rows);
                            r_count     <= '0;
                            r_clr_addr  <= '0;
                        end else if (r_count != '0) begin
                            r_lfsr     <= rpmc_pkg::lfsr_next(r_lfsr);
                            r_dividend <= rpmc_pkg::lfsr_next(r_lfsr);
                            r_divisor  <= r_count;
                            r_rem      <= '0;
                            r_bit      <= '0;
                            r_second   <= 1'b0;
                        end
                    end
                end
                rpmc_pkg::S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                rpmc_pkg::S_DIV: begin
                    r_rem      <= n_rem;
                    r_dividend <= r_dividend << 1;
                    r_bit      <= r_bit + 1'b1;
                    r_idx      <= rpmc_pkg::IDX_W'(n_rem);
                    r_k        <= n_rem[1:0];
                end
                rpmc_pkg::S_FRD_LAST: begin
                    r_row <= f_rdata[rpmc_pkg::CELL_W-1:rpmc_pkg::COL_W];
                    r_col <= f_rdata[rpmc_pkg::COL_W-1:0];
                end
                rpmc_pkg::S_FSWAP: begin
                    r_count <= r_count - 1'b1;
                end
                rpmc_pkg::S_MARK: begin
                    r_d      <= '0;
                    r_inmaze <= '0;
                    r_unv    <= '0;
                end
                rpmc_pkg::S_NREAD: begin
                    if ((r_d != 3'd0) && (r_d != 3'd5) && nb_ok[cap_d]) begin
                        r_inmaze[cap_d] <= (m_rdata == rpmc_pkg::MARK_INMAZE);
                        r_unv[cap_d]    <= (m_rdata == rpmc_pkg::MARK_UNVISITED);
                    end
                    if (r_d == 3'd5) begin
                        r_d <= '0;
                        if (!r_restart && (r_inmaze != '0)) begin
                            r_lfsr     <= rpmc_pkg::lfsr_next(r_lfsr);
                            r_dividend <= rpmc_pkg::lfsr_next(r_lfsr);
                            r_divisor  <= rpmc_pkg::CNT_W'($countones(r_inmaze));
                            r_rem      <= '0;
                            r_bit      <= '0;
                            r_second   <= 1'b1;
                        end
                    end else begin
                        r_d <= r_d + 3'd1;
                    end
                end
                rpmc_pkg::S_PICK: begin
                    r_dir    <= pick_dir;
                    r_carved <= 1'b1;
                end
                rpmc_pkg::S_GROW: begin
                    r_d <= r_d + 3'd1;
                    if (grow_ok) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    rpmc_ram #(
        .WIDTH (2),
        .DEPTH (rpmc_pkg::MARK_DEPTH)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    rpmc_ram #(
        .WIDTH (rpmc_pkg::CELL_W),
        .DEPTH (rpmc_pkg::CELL_TOTAL)
    ) u_frontier_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rpmc_pkg::CNT_W'(rpmc_pkg::CELL_TOTAL))
        else $error("frontier count beyond capacity");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("LFSR reached the all-zero state");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> !o_valid)
        else $error("second result without a new transaction");

    a_restart_no_carve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_restart) |-> (!o_carved && o_cell_col == '0 && o_cell_row == '0))
        else $error("restart result not at origin");

endmodule

>>> tb/random_prim_maze_carver_test.sv
module random_prim_maze_carver_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rpmc_pkg::CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [rpmc_pkg::CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;
    localparam int QUIET_LIMIT    = 8000;
    localparam int RANDOM_ITEMS   = 600;
    localparam int LONG_HOLD      = 500;

    typedef struct packed {
        logic        restart;
        logic [15:0] seed;
    } t_item;

    typedef struct packed {
        logic       carved;
        logic [4:0] col;
        logic [4:0] row;
        logic [1:0] dir;
        logic       done;
    } t_carve;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic                           o_stall;
    logic                           i_restart   = 1'b0;
    logic [15:0]                    i_seed      = '0;
    logic                           o_valid;
    logic                           i_stall     = 1'b0;
    logic                           o_carved;
    logic [4:0]                     o_cell_col;
    logic [4:0]                     o_cell_row;
    logic [1:0]                     o_direction;
    logic                           o_done_res;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [rpmc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rpmc_pkg::CFG_W-1:0]     i_cfg_data  = '0;

    random_prim_maze_carver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_restart   (i_restart),
        .i_seed      (i_seed),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_carved    (o_carved),
        .o_cell_col  (o_cell_col),
        .o_cell_row  (o_cell_row),
        .o_direction (o_direction),
        .o_done_res  (o_done_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // maze state as the block should hold it
    logic [1:0]                 mark_q  [rpmc_pkg::CELL_TOTAL];
    logic [rpmc_pkg::IDX_W-1:0] front_q [rpmc_pkg::CELL_TOTAL];
    int unsigned                front_cnt;
    logic [15:0]                lfsr_q;
    logic [rpmc_pkg::CFG_W-1:0] cols_reg;
    logic [rpmc_pkg::CFG_W-1:0] rows_reg;
    int unsigned                live_c;
    int unsigned                live_r;

    t_item  pending [$];
    t_carve carve_exp [$];
    t_item  offered;

    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    bit long_hold_req  = 1'b0;
    bit long_hold_used = 1'b0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    int items_queued  = 0;
    int items_in      = 0;
    int restarts_in   = 0;
    int results_seen  = 0;
    int mazes_done    = 0;
    int cfg_writes    = 0;
    int errors        = 0;
    int dir_seen [4]  = '{0, 0, 0, 0};

    function automatic int unsigned clamp_dim(input logic [rpmc_pkg::CFG_W-1:0] v,
                                              input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return 32'(v);
    endfunction

    function automatic int unsigned lfsr_draw(input int unsigned n);
        logic [15:0] s;
        s = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? rpmc_pkg::LFSR_TAPS : 16'h0000);
        lfsr_q = s;
        return (n == 0) ? 0 : (s % n);
    endfunction

    function automatic bit neighbour(input int unsigned cell_no, input logic [1:0] dir,
                                     output int unsigned nb);
        int unsigned row;
        int unsigned col;
        row = cell_no / rpmc_pkg::MAX_COLS;
        col = cell_no % rpmc_pkg::MAX_COLS;
        nb  = 0;
        case (dir)
            rpmc_pkg::DIR_UP: begin
                if (row == 0) return 1'b0;
                row = row - 1;
            end
            rpmc_pkg::DIR_DOWN: begin
                if (row + 1 >= live_r) return 1'b0;
                row = row + 1;
            end
            rpmc_pkg::DIR_LEFT: begin
                if (col == 0) return 1'b0;
                col = col - 1;
            end
            default: begin
                if (col + 1 >= live_c) return 1'b0;
                col = col + 1;
            end
        endcase
        nb = row * rpmc_pkg::MAX_COLS + col;
        return 1'b1;
    endfunction

    task automatic grow_frontier(input int unsigned cell_no);
        int unsigned nb;
        int d;
        for (d = 0; d < 4; d++) begin
            if (neighbour(cell_no, 2'(d), nb) && mark_q[nb] == rpmc_pkg::MARK_UNVISITED &&
                front_cnt < rpmc_pkg::CELL_TOTAL) begin
                mark_q[nb] = rpmc_pkg::MARK_FRONTIER;
                front_q[front_cnt] = rpmc_pkg::IDX_W'(nb);
                front_cnt++;
            end
        end
    endtask

    task automatic carve_predict(input t_item it);
        t_carve      r;
        int unsigned idx;
        int unsigned cur;
        int unsigned nb;
        int unsigned n;
        int          d;
        logic [1:0]  open_dirs [4];
        r = '0;
        if (it.restart) begin
            lfsr_q = (it.seed == 0) ? 16'd1 : it.seed;
            live_c = clamp_dim(cols_reg, rpmc_pkg::MAX_COLS);
            live_r = clamp_dim(rows_reg, rpmc_pkg::MAX_ROWS);
            foreach (mark_q[k]) mark_q[k] = rpmc_pkg::MARK_UNVISITED;
            front_cnt = 0;
            mark_q[0] = rpmc_pkg::MARK_INMAZE;
            grow_frontier(0);
        end else if (front_cnt != 0) begin
            idx = lfsr_draw(front_cnt);
            cur = 32'(front_q[idx]);
            front_q[idx] = front_q[front_cnt - 1];
            front_cnt--;
            mark_q[cur] = rpmc_pkg::MARK_INMAZE;
            n = 0;
            for (d = 0; d < 4; d++) begin
                if (neighbour(cur, 2'(d), nb) && mark_q[nb] == rpmc_pkg::MARK_INMAZE) begin
                    open_dirs[n] = 2'(d);
                    n++;
                end
            end
            if (n != 0) begin
                r.dir    = open_dirs[lfsr_draw(n)];
                r.carved = 1'b1;
            end
            r.row = 5'(cur / rpmc_pkg::MAX_COLS);
            r.col = 5'(cur % rpmc_pkg::MAX_COLS);
            grow_frontier(cur);
        end
        r.done = (front_cnt == 0);
        carve_exp = {carve_exp, r};
    endtask

    always @(posedge i_clk) begin : drv
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                carve_predict(offered);
                items_in++;
                if (offered.restart) restarts_in++;
            end
            if (!i_valid || !o_stall) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending.pop_front();
                    i_valid   <= 1'b1;
                    i_restart <= offered.restart;
                    i_seed    <= offered.seed;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : rx
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (long_hold_req && !long_hold_used && o_valid) begin
            i_stall        <= 1'b1;
            hold_left      <= LONG_HOLD;
            long_hold_used <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : mon
        t_carve want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (carve_exp.size() == 0) begin
                $error("result transaction with no item outstanding");
                errors++;
            end else begin
                want = carve_exp.pop_front();
                if (o_carved !== want.carved) begin
                    $error("carved: expected %0d, got %0d", want.carved, o_carved);
                    errors++;
                end
                if (o_cell_col !== want.col) begin
                    $error("cell_col: expected %0d, got %0d", want.col, o_cell_col);
                    errors++;
                end
                if (o_cell_row !== want.row) begin
                    $error("cell_row: expected %0d, got %0d", want.row, o_cell_row);
                    errors++;
                end
                if (o_direction !== want.dir) begin
                    $error("direction: expected %0d, got %0d", want.dir, o_direction);
                    errors++;
                end
                if (o_done_res !== want.done) begin
                    $error("done_res: expected %0d, got %0d", want.done, o_done_res);
                    errors++;
                end
                if (want.carved) dir_seen[want.dir]++;
                if (want.carved && want.done) mazes_done++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("random_prim_maze_carver regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [rpmc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rpmc_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == rpmc_pkg::CFG_GRID_COLS) cols_reg = val;
        else if (idx == rpmc_pkg::CFG_GRID_ROWS) rows_reg = val;
        cfg_writes++;
    endtask

    task automatic set_grid(input logic [rpmc_pkg::CFG_W-1:0] cols,
                            input logic [rpmc_pkg::CFG_W-1:0] rows);
        write_reg(rpmc_pkg::CFG_GRID_COLS, cols);
        write_reg(rpmc_pkg::CFG_GRID_ROWS, rows);
    endtask

    task automatic add_items(input bit with_restart, input logic [15:0] seed, input int steps);
        t_item it;
        if (with_restart) begin
            it.restart = 1'b1;
            it.seed    = seed;
            pending = {pending, it};
            items_queued++;
        end
        repeat (steps) begin
            it.restart = 1'b0;
            it.seed    = 16'($urandom);
            pending = {pending, it};
            items_queued++;
        end
    endtask

    task automatic drain();
        while (results_seen < items_queued) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin send_idle_pct = 66; rx_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rx_stall_pct = 66; end
            default: begin send_idle_pct = 26; rx_stall_pct = 26; end
        endcase
    endtask

    initial begin : stim
        logic [rpmc_pkg::CFG_W-1:0] gc;
        logic [rpmc_pkg::CFG_W-1:0] gr;
        logic [15:0]                sd;
        int unsigned                area;
        int                         steps;
        int                         maze_no;
        int                         directed_items;

        foreach (mark_q[k]) mark_q[k] = rpmc_pkg::MARK_UNVISITED;
        foreach (front_q[k]) front_q[k] = '0;
        front_cnt = 0;
        lfsr_q    = 16'd1;
        cols_reg  = 6'd32;
        rows_reg  = 6'd32;
        live_c    = rpmc_pkg::MAX_COLS;
        live_r    = rpmc_pkg::MAX_ROWS;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0);
        add_items(1'b0, 16'h0000, 2);
        drain();
        set_grid(6'd1, 6'd1);
        add_items(1'b1, 16'h0000, 1);
        drain();
        write_reg(CFG_SPARE2, 6'h3F);
        write_reg(CFG_SPARE3, 6'h00);
        set_grid(6'd2, 6'd2);
        add_items(1'b1, 16'hFFFF, 4);
        drain();
        set_grid(6'd0, 6'd2);
        add_items(1'b1, 16'h8000, 2);
        drain();
        set_grid(6'd3, 6'd3);
        add_items(1'b1, 16'h1234, 2);
        add_items(1'b1, 16'h0001, 3);
        drain();
        // new sizes must not apply until the next restart
        set_grid(6'd5, 6'd63);
        add_items(1'b0, 16'h0000, 3);
        drain();
        directed_items = items_queued;

        maze_no = 0;
        while (items_queued - directed_items < RANDOM_ITEMS) begin
            set_idling((maze_no / 2) % 4);
            case ($urandom_range(9))
                0: begin
                    if ($urandom_range(1)) begin
                        gc = 6'd32;
                        gr = 6'($urandom_range(1, 2));
                    end else begin
                        gr = 6'd32;
                        gc = 6'($urandom_range(1, 2));
                    end
                end
                1: begin
                    gc = 6'($urandom_range(0, 63));
                    gr = 6'($urandom_range(0, 63));
                end
                default: begin
                    gc = 6'($urandom_range(1, 8));
                    gr = 6'($urandom_range(1, 8));
                end
            endcase
            if (maze_no == 1) begin
                gc = 6'd6;
                gr = 6'd6;
                long_hold_req = 1'b1;
            end
            area = clamp_dim(gc, rpmc_pkg::MAX_COLS) * clamp_dim(gr, rpmc_pkg::MAX_ROWS);
            if (area <= 72) steps = area - 1 + $urandom_range(0, 2);
            else steps = $urandom_range(20, 60);
            if (maze_no != 1 && $urandom_range(9) == 0) steps = $urandom_range(0, steps);
            sd = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom);
            set_grid(gc, gr);
            if ($urandom_range(7) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE2 : CFG_SPARE3, 6'($urandom));
            add_items(1'b1, sd, steps);
            drain();
            maze_no++;
        end

        repeat (40) @(posedge i_clk);
        if (carve_exp.size() != 0) begin
            $error("%0d results never arrived", carve_exp.size());
            errors++;
        end
        $display("%0d items over %0d maze starts, %0d results checked, %0d mazes carved out,",
                 items_in, restarts_in, results_seen, mazes_done);
        $display("%0d register writes; passages by direction: up %0d, down %0d, left %0d, right %0d",
                 cfg_writes, dir_seen[0], dir_seen[1], dir_seen[2], dir_seen[3]);
        if (errors == 0) begin
            $display("random_prim_maze_carver regression: pass");
        end else begin
            $display("random_prim_maze_carver regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
src/rpmc_pkg.sv
src/rpmc_ram.sv
src/random_prim_maze_carver.sv
tb/random_prim_maze_carver_test.sv
